>>> rtl/core/gtmts_pkg.sv
// Shared types and constants for the grouped top-k minimum time selector.
package gtmts_pkg;

    localparam int TOP_COUNT  = 3;
    localparam int INDEX_BITS = 10;
    localparam int TIME_W     = 32;
    localparam int GROUP_W    = 16;
    localparam int PORT_IDX_W = 10;
    localparam int RANK_W     = 2;

    // rank counter and insert position widths
    localparam int CNT_W  = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int CNTP_W = $clog2(TOP_COUNT + 1);

    typedef logic [INDEX_BITS-1:0] t_idx;
    typedef logic [GROUP_W-1:0]    t_grp;
    typedef logic [RANK_W-1:0]     t_rank;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CNTP_W-1:0]     t_pos;

    typedef struct {
        logic               vld;
        logic signed [TIME_W-1:0] tm;
        t_idx               idx;
        t_grp               grp;
    } t_slot;

    localparam t_slot SLOT_EMPTY = '{vld: 1'b0, tm: '0, idx: '0, grp: '0};

    localparam t_cnt LAST_RANK = t_cnt'(TOP_COUNT - 1);

endpackage

>>> rtl/core/grouped_top3_min_time_select_top.sv
// Grouped top-k minimum time selector: sorted per-group best list and rank output.
// Latency: the list updates in the cycle an entry word is accepted; rank words for a
//   last-marked entry start the next cycle, one per rank, TOP_COUNT words per set.
// Throughput: one entry word per cycle; a last-marked entry is held off only while the
//   previous set's rank words are still draining from the snapshot register.
// Reset (i_rst_n low, synchronous): clears the list and drops any pending rank words.
module grouped_top3_min_time_select_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [9:0]  i_entry_index,
    input  logic signed [31:0] i_entry_time,
    input  logic [15:0] i_group_key,
    input  logic        i_first_entry,
    input  logic        i_last_entry,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_rank,
    output logic [9:0]  o_best_index,
    output logic        o_rank_valid,
    output logic        o_run_end
);

    gtmts_pkg::t_slot r_slot [gtmts_pkg::TOP_COUNT];
    gtmts_pkg::t_slot n_slot [gtmts_pkg::TOP_COUNT];
    gtmts_pkg::t_slot r_snap [gtmts_pkg::TOP_COUNT];
    logic             r_busy;
    gtmts_pkg::t_cnt  r_cnt;

    gtmts_pkg::t_slot w_base [gtmts_pkg::TOP_COUNT];
    gtmts_pkg::t_slot w_ext  [gtmts_pkg::TOP_COUNT+1];
    gtmts_pkg::t_slot w_cmp  [gtmts_pkg::TOP_COUNT];
    gtmts_pkg::t_slot w_pre  [gtmts_pkg::TOP_COUNT+1];
    gtmts_pkg::t_slot w_new;
    logic             w_tpos;
    logic             w_found;
    logic             w_full;
    logic             w_do;
    logic             w_rem;
    gtmts_pkg::t_cnt  w_fpos;
    gtmts_pkg::t_cnt  w_rpos;
    logic signed [gtmts_pkg::TIME_W-1:0] w_ftime;
    gtmts_pkg::t_pos  w_pos;
    logic             w_in_acc;
    logic             w_drain_done;

    assign w_drain_done = r_busy && i_out_ready && (r_cnt == gtmts_pkg::LAST_RANK);
    // only a set end has to wait for the snapshot to free up
    assign o_in_ready   = !(i_last_entry && r_busy && !w_drain_done);
    assign w_in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        w_tpos  = $signed(i_entry_time) > 32'sd0;
        w_new   = '{vld: 1'b1, tm: i_entry_time,
                    idx: gtmts_pkg::t_idx'(i_entry_index), grp: i_group_key};
        w_found = 1'b0;
        w_fpos  = '0;
        w_ftime = '0;
        for (int i = 0; i < gtmts_pkg::TOP_COUNT; i++) begin
            w_base[i] = i_first_entry ? gtmts_pkg::SLOT_EMPTY : r_slot[i];
        end
        // groups in the list are unique, so at most one slot matches
        for (int i = 0; i < gtmts_pkg::TOP_COUNT; i++) begin
            if (w_base[i].vld && (w_base[i].grp == i_group_key)) begin
                w_found = 1'b1;
                w_fpos  = w_fpos | gtmts_pkg::t_cnt'(i);
                w_ftime = w_ftime | w_base[i].tm;
            end
        end
        w_full = w_base[gtmts_pkg::TOP_COUNT-1].vld;
        if (w_found) begin
            w_do = w_tpos && ($signed(i_entry_time) < $signed(w_ftime));
        end else begin
            w_do = w_tpos && (!w_full ||
                   ($signed(i_entry_time) < $signed(w_base[gtmts_pkg::TOP_COUNT-1].tm)));
        end
        w_rem  = w_do && (w_found || w_full);
        w_rpos = w_found ? w_fpos : gtmts_pkg::LAST_RANK;

        // close the gap at the removed place
        for (int j = 0; j < gtmts_pkg::TOP_COUNT; j++) begin
            w_ext[j] = w_base[j];
        end
        w_ext[gtmts_pkg::TOP_COUNT] = gtmts_pkg::SLOT_EMPTY;
        for (int j = 0; j < gtmts_pkg::TOP_COUNT; j++) begin
            w_cmp[j] = (w_rem && (gtmts_pkg::t_cnt'(j) >= w_rpos)) ? w_ext[j+1] : w_ext[j];
        end

        // new word goes after every entry with time <= its own
        w_pos = '0;
        for (int j = 0; j < gtmts_pkg::TOP_COUNT; j++) begin
            w_pos = w_pos + gtmts_pkg::t_pos'(w_cmp[j].vld &&
                    ($signed(w_cmp[j].tm) <= $signed(i_entry_time)));
        end

        w_pre[0] = gtmts_pkg::SLOT_EMPTY;
        for (int k = 0; k < gtmts_pkg::TOP_COUNT; k++) begin
            w_pre[k+1] = w_cmp[k];
        end

        for (int k = 0; k < gtmts_pkg::TOP_COUNT; k++) begin
            if (!w_do) begin
                n_slot[k] = w_base[k];
            end else if (gtmts_pkg::t_pos'(k) < w_pos) begin
                n_slot[k] = w_cmp[k];
            end else if (gtmts_pkg::t_pos'(k) == w_pos) begin
                n_slot[k] = w_new;
            end else begin
                n_slot[k] = w_pre[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gtmts_pkg::TOP_COUNT; i++) begin
                r_slot[i] <= gtmts_pkg::SLOT_EMPTY;
                r_snap[i] <= gtmts_pkg::SLOT_EMPTY;
            end
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_in_acc) begin
                for (int i = 0; i < gtmts_pkg::TOP_COUNT; i++) begin
                    r_slot[i] <= n_slot[i];
                end
            end
            if (w_in_acc && i_last_entry) begin
                for (int i = 0; i < gtmts_pkg::TOP_COUNT; i++) begin
                    r_snap[i] <= n_slot[i];
                end
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && i_out_ready) begin
                if (r_cnt == gtmts_pkg::LAST_RANK) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_out_valid  = r_busy;
    assign o_rank       = gtmts_pkg::t_rank'(r_cnt);
    assign o_rank_valid = r_snap[r_cnt].vld;
    assign o_best_index = r_snap[r_cnt].vld ?
                          gtmts_pkg::PORT_IDX_W'(r_snap[r_cnt].idx) : '0;
    assign o_run_end    = (r_cnt == gtmts_pkg::LAST_RANK);

endmodule

>>> rtl/core/gtmts_chk.sv
// Port-level checker for the grouped top-k selector, bound to the top level.
module gtmts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [9:0]  i_entry_index,
    input logic signed [31:0] i_entry_time,
    input logic [15:0] i_group_key,
    input logic        i_first_entry,
    input logic        i_last_entry,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_rank,
    input logic [9:0]  o_best_index,
    input logic        o_rank_valid,
    input logic        o_run_end
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rank) &&
        $stable(o_best_index) && $stable(o_rank_valid))
        else $error("output word changed while stalled");

    // ranks of one set come out in order without gaps
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_run_end |=>
        o_out_valid && (o_rank == $past(o_rank) + 2'd1))
        else $error("rank sequence broken");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_end == (o_rank == 2'(gtmts_pkg::TOP_COUNT - 1))))
        else $error("run end not on final rank");

    // filled places form a prefix of the list
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_rank_valid && !o_run_end |=> !o_rank_valid)
        else $error("valid rank after empty rank");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rank_valid |-> (o_best_index == 10'd0))
        else $error("empty rank carries an index");

endmodule

bind grouped_top3_min_time_select_top gtmts_chk u_gtmts_chk (.*);

>>> sim/grouped_top3_min_time_select_top_test.sv
// Self-checking testbench for the grouped top-3 minimum time selector.
`timescale 1ns / 100ps

module grouped_top3_min_time_select_top_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_ENTRIES  = 320;
    localparam int CALM_TAIL      = 40;

    typedef struct {
        gtmts_pkg::t_idx    idx;
        logic signed [31:0] tm;
        gtmts_pkg::t_grp    grp;
        logic               first;
        logic               last;
        int                 gap;
        bit                 drain;
    } t_entry;

    typedef struct {
        gtmts_pkg::t_rank rank;
        gtmts_pkg::t_idx  idx;
        logic             vld;
        logic             run_end;
    } t_rank_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [9:0]         i_entry_index = '0;
    logic signed [31:0] i_entry_time = '0;
    logic [15:0]        i_group_key = '0;
    logic               i_first_entry = 1'b0;
    logic               i_last_entry = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_rank;
    logic [9:0]         o_best_index;
    logic               o_rank_valid;
    logic               o_run_end;

    grouped_top3_min_time_select_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_entry_index (i_entry_index),
        .i_entry_time  (i_entry_time),
        .i_group_key   (i_group_key),
        .i_first_entry (i_first_entry),
        .i_last_entry  (i_last_entry),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rank        (o_rank),
        .o_best_index  (o_best_index),
        .o_rank_valid  (o_rank_valid),
        .o_run_end     (o_run_end)
    );

    always #4 i_clk = ~i_clk;

    t_entry           entries_pending[$];
    t_rank_word       ranks_due[$];
    gtmts_pkg::t_slot best_list[gtmts_pkg::TOP_COUNT];
    t_entry           cur_entry;
    int               entries_taken = 0;
    int               calm_from = 0;
    int               fail_count = 0;
    int               quiet_cycles = 0;
    int               gap_left = 0;
    bit               gap_armed = 1'b0;
    int               stall_left = 0;

    initial begin
        foreach (best_list[i]) best_list[i] = gtmts_pkg::SLOT_EMPTY;
    end

    // Track the sorted per-group best list; on a last mark, queue one word per rank.
    task automatic update_best_list(input t_entry e);
        int         n;
        int         hit;
        int         pos;
        int         drop;
        bit         take;
        t_rank_word w;
        if (e.first) begin
            foreach (best_list[i]) best_list[i] = gtmts_pkg::SLOT_EMPTY;
        end
        if (e.tm > 0) begin
            n = 0;
            while (n < gtmts_pkg::TOP_COUNT && best_list[n].vld) n++;
            hit = -1;
            for (int i = 0; i < n; i++) begin
                if (hit < 0 && best_list[i].grp == e.grp) hit = i;
            end
            take = 1'b0;
            drop = -1;
            if (hit >= 0) begin
                if (e.tm < best_list[hit].tm) begin
                    take = 1'b1;
                    drop = hit;
                end
            end else if (n < gtmts_pkg::TOP_COUNT) begin
                take = 1'b1;
            end else if (e.tm < best_list[gtmts_pkg::TOP_COUNT-1].tm) begin
                take = 1'b1;
                drop = gtmts_pkg::TOP_COUNT - 1;
            end
            if (take) begin
                if (drop >= 0) begin
                    for (int i = drop; i < n - 1; i++) best_list[i] = best_list[i+1];
                    n--;
                    best_list[n] = gtmts_pkg::SLOT_EMPTY;
                end
                // ties stay ahead of the newcomer
                pos = 0;
                while (pos < n && best_list[pos].tm <= e.tm) pos++;
                for (int i = n; i > pos; i--) best_list[i] = best_list[i-1];
                best_list[pos] = '{vld: 1'b1, tm: e.tm, idx: e.idx, grp: e.grp};
            end
        end
        if (e.last) begin
            for (int i = 0; i < gtmts_pkg::TOP_COUNT; i++) begin
                w.rank    = gtmts_pkg::t_rank'(i);
                w.vld     = best_list[i].vld;
                w.idx     = best_list[i].vld ? best_list[i].idx : '0;
                w.run_end = (i == gtmts_pkg::TOP_COUNT - 1);
                ranks_due.insert(ranks_due.size(), w);
            end
        end
    endtask

    task automatic queue_entry(input gtmts_pkg::t_idx idx, input logic signed [31:0] tm,
                               input gtmts_pkg::t_grp grp,
                               input bit first, input bit last, input bit drain);
        t_entry e;
        e.idx   = idx;
        e.tm    = tm;
        e.grp   = grp;
        e.first = first;
        e.last  = last;
        e.drain = drain;
        e.gap   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        entries_pending.insert(entries_pending.size(), e);
    endtask

    function automatic logic signed [31:0] pick_time();
        case ($urandom_range(0, 9))
            0:       pick_time = $urandom();
            1:       pick_time = -$signed($urandom_range(0, 5));
            2:       pick_time = 32'sh7FFF_FFFF - $urandom_range(0, 3);
            default: pick_time = $urandom_range(1, 24);
        endcase
    endfunction

    function automatic gtmts_pkg::t_grp pick_group();
        pick_group = ($urandom_range(0, 3) == 0) ?
                     gtmts_pkg::t_grp'($urandom_range(0, 65535)) :
                     gtmts_pkg::t_grp'($urandom_range(0, 4));
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit present;
        present = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                update_best_list(cur_entry);
                entries_taken++;
                present = 1'b0;
            end
            if (!present && entries_pending.size() > 0) begin
                if (!gap_armed) begin
                    gap_left  = entries_pending[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!entries_pending[0].drain || ranks_due.size() == 0) begin
                    cur_entry = entries_pending.pop_front();
                    gap_armed = 1'b0;
                    present   = 1'b1;
                end
            end
        end
        i_in_valid    <= present;
        i_entry_index <= cur_entry.idx;
        i_entry_time  <= cur_entry.tm;
        i_group_key   <= cur_entry.grp;
        i_first_entry <= cur_entry.first;
        i_last_entry  <= cur_entry.last;
    end

    // monitor
    always @(posedge i_clk) begin
        bit         take;
        t_rank_word want;
        take = 1'b1;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (ranks_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: rank %0d index %0d valid %0b end %0b",
                                 o_rank, o_best_index, o_rank_valid, o_run_end);
                end else begin
                    want = ranks_due.pop_front();
                    if (o_rank !== want.rank || o_best_index !== want.idx ||
                        o_rank_valid !== want.vld || o_run_end !== want.run_end) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                                     want.rank, want.idx, want.vld, want.run_end,
                                     o_rank, o_best_index, o_rank_valid, o_run_end);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end else if (entries_taken < calm_from && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                take = 1'b0;
            end
        end
        i_out_ready <= take;
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int set_len;
        // directed: extremes, ties, replacement, eviction, ignored times
        queue_entry(10'd0,    32'sd100,        16'd5,     1, 0, 0);
        queue_entry(10'd1023, 32'sh7FFF_FFFF,  16'd65535, 0, 0, 0);
        queue_entry(10'd1,    32'sd0,          16'd7,     0, 0, 0);
        queue_entry(10'd2,    -32'sd1,         16'd7,     0, 0, 0);
        queue_entry(10'd3,    32'sh8000_0000,  16'd8,     0, 0, 0);
        queue_entry(10'd4,    32'sd50,         16'd5,     0, 0, 0);
        queue_entry(10'd5,    32'sd50,         16'd5,     0, 0, 0);
        queue_entry(10'd6,    32'sd50,         16'd9,     0, 0, 0);
        queue_entry(10'd7,    32'sh7FFF_FFFF,  16'd10,    0, 0, 0);
        queue_entry(10'd8,    32'sd60,         16'd11,    0, 0, 0);
        queue_entry(10'd9,    32'sd40,         16'd11,    0, 1, 0);
        // list survives emission until the next first mark
        queue_entry(10'd0,    32'sd0,          16'd0,     0, 1, 0);
        queue_entry(10'd10,   32'sd1,          16'd0,     1, 1, 1);
        queue_entry(10'd0,    32'sd0,          16'd0,     1, 1, 0);
        queue_entry(10'd11,   32'sd30,         16'd1,     1, 0, 0);
        queue_entry(10'd12,   32'sd20,         16'd2,     0, 0, 0);
        queue_entry(10'd13,   32'sd10,         16'd1,     0, 0, 0);
        queue_entry(10'd14,   -32'sd5,         16'd3,     0, 1, 0);
        queue_entry(10'd1023, 32'sd5,          16'd65535, 1, 1, 0);

        while (entries_pending.size() < TOTAL_ENTRIES) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_entry(gtmts_pkg::t_idx'($urandom_range(0, 1023)), $urandom(),
                            gtmts_pkg::t_grp'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0);
            end else begin
                set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                      : $urandom_range(1, 7);
                for (int k = 0; k < set_len; k++)
                    queue_entry(gtmts_pkg::t_idx'($urandom_range(0, 1023)), pick_time(),
                                pick_group(), k == 0, k == set_len - 1,
                                k == 0 && $urandom_range(0, 29) == 0);
            end
        end
        for (int k = entries_pending.size() - CALM_TAIL; k < entries_pending.size(); k++)
            entries_pending[k].gap = 0;
        calm_from = entries_pending.size() - CALM_TAIL;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (entries_pending.size() != 0 || i_in_valid || ranks_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        // anything still owed at this point never came out
        if (entries_pending.size() != 0 || ranks_due.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> grouped_top3_min_time_select_top.f
rtl/core/gtmts_pkg.sv
rtl/core/grouped_top3_min_time_select_top.sv
rtl/core/gtmts_chk.sv
sim/grouped_top3_min_time_select_top_test.sv
